/* hdl/hacl_pkg.sv */
// hacl_pkg: shared types, constants and the pixel smoothing function for the
// hires artifact color line block.
// No dependencies; used by every module under hdl.
package hacl_pkg;

	// line geometry
	localparam int PIXELS_PER_BYTE = 7;
	localparam int BYTES_PER_LINE  = 40;
	localparam int WIN_DEPTH       = 10;
	localparam int CTX_LEN         = WIN_DEPTH + PIXELS_PER_BYTE + 2;
	localparam int MAX_OUT         = 2 * PIXELS_PER_BYTE;
	localparam int CNT_W           = $clog2(MAX_OUT + 1);
	localparam int COL_W           = 6;
	localparam int BYTE_W          = 8;

	typedef logic [3:0] color_t;
	typedef logic [CNT_W-1:0] cnt_t;

	// palette indices
	localparam color_t COLOR_BLACK  = 4'd0;
	localparam color_t COLOR_PURPLE = 4'd3;
	localparam color_t COLOR_BLUE   = 4'd6;
	localparam color_t COLOR_ORANGE = 4'd9;
	localparam color_t COLOR_GREEN  = 4'd12;
	localparam color_t COLOR_WHITE  = 4'd15;

	// last column of a line, as a column value
	localparam logic [COL_W-1:0] LAST_COLUMN = COL_W'(BYTES_PER_LINE - 1);

	// bit of the video byte that picks the blue/orange pair
	localparam int PAL_BIT = 7;

	// control of one batch of pixels handed to the output buffer
	typedef struct packed {
		cnt_t count;
		logic eol;
	} batch_ctl_t;

	// final color of a pixel from its raw color and two neighbors on each side
	function automatic color_t final_color(color_t l2, color_t l, color_t raw,
			color_t r, color_t r2, logic mono);
		color_t res;
		res = COLOR_BLACK;
		if (mono) begin
			res = (raw != COLOR_BLACK) ? COLOR_WHITE : COLOR_BLACK;
		end else if (raw != COLOR_BLACK) begin
			res = (l != COLOR_BLACK || r != COLOR_BLACK) ? COLOR_WHITE : raw;
		end else if (l != COLOR_BLACK && l == r && l2 == COLOR_BLACK
				&& r2 == COLOR_BLACK) begin
			res = l;
		end
		return res;
	endfunction

endpackage

/* hdl/hacl_pixel_unit.sv */
// hacl_pixel_unit: expands one video byte into raw artifact colors, smooths the
// pending and current byte against the pixel window and builds the next window.
// Depends on hacl_pkg.
module hacl_pixel_unit (
	input  logic [hacl_pkg::BYTE_W-1:0] video_byte,
	input  logic [hacl_pkg::COL_W-1:0]  column,
	input  logic                        mono,
	input  hacl_pkg::color_t            win [hacl_pkg::WIN_DEPTH],
	input  logic                        win_valid,
	output hacl_pkg::color_t            colors [hacl_pkg::MAX_OUT],
	output hacl_pkg::batch_ctl_t        ctl,
	output hacl_pkg::color_t            next_win [hacl_pkg::WIN_DEPTH],
	output logic                        next_valid
);

	hacl_pkg::color_t ctx [hacl_pkg::CTX_LEN];
	hacl_pkg::color_t fin [hacl_pkg::MAX_OUT];
	hacl_pkg::color_t c_even;
	hacl_pkg::color_t c_odd;
	logic             clear_win;
	logic             pending;
	logic             ends;

	// line start and end decode
	assign clear_win = (column == '0) || !win_valid;
	assign pending   = !clear_win;
	assign ends      = column >= hacl_pkg::LAST_COLUMN;

	// artifact pair from palette bit and column parity
	always_comb begin
		if (video_byte[hacl_pkg::PAL_BIT]) begin
			c_even = hacl_pkg::COLOR_BLUE;
			c_odd  = hacl_pkg::COLOR_ORANGE;
		end else begin
			c_even = hacl_pkg::COLOR_PURPLE;
			c_odd  = hacl_pkg::COLOR_GREEN;
		end
		if (column[0]) begin
			c_even = c_odd;
			c_odd  = video_byte[hacl_pkg::PAL_BIT] ? hacl_pkg::COLOR_BLUE
				: hacl_pkg::COLOR_PURPLE;
		end
	end

	// context: window, new raw pixels, two dark pixels past the byte
	always_comb begin
		for (int i = 0; i < hacl_pkg::WIN_DEPTH; i++) begin
			ctx[i] = clear_win ? hacl_pkg::COLOR_BLACK : win[i];
		end
		for (int i = 0; i < hacl_pkg::PIXELS_PER_BYTE; i++) begin
			if (video_byte[i]) begin
				ctx[hacl_pkg::WIN_DEPTH + i] = (i % 2 == 1) ? c_odd : c_even;
			end else begin
				ctx[hacl_pkg::WIN_DEPTH + i] = hacl_pkg::COLOR_BLACK;
			end
		end
		ctx[hacl_pkg::CTX_LEN - 2] = hacl_pkg::COLOR_BLACK;
		ctx[hacl_pkg::CTX_LEN - 1] = hacl_pkg::COLOR_BLACK;
	end

	// smoothing of the pending byte and the current byte
	localparam int FIRST = hacl_pkg::WIN_DEPTH - hacl_pkg::PIXELS_PER_BYTE;
	for (genvar j = 0; j < hacl_pkg::MAX_OUT; j++) begin : g_fin
		assign fin[j] = hacl_pkg::final_color(ctx[FIRST + j - 2], ctx[FIRST + j - 1],
			ctx[FIRST + j], ctx[FIRST + j + 1], ctx[FIRST + j + 2], mono);
	end

	// batch layout: pending byte first, then the current byte on a line end; with no pending byte the current byte leads
	always_comb begin
		for (int j = 0; j < hacl_pkg::MAX_OUT; j++) begin
			if (pending || j >= hacl_pkg::PIXELS_PER_BYTE) begin
				colors[j] = fin[j];
			end else begin
				colors[j] = fin[j + hacl_pkg::PIXELS_PER_BYTE];
			end
		end
		ctl.count = (pending ? hacl_pkg::cnt_t'(hacl_pkg::PIXELS_PER_BYTE) : '0)
			+ (ends ? hacl_pkg::cnt_t'(hacl_pkg::PIXELS_PER_BYTE) : '0);
		ctl.eol = ends;
	end

	// next window slides by one byte, or clears at the end of a line
	always_comb begin
		for (int i = 0; i < hacl_pkg::WIN_DEPTH; i++) begin
			next_win[i] = ends ? hacl_pkg::COLOR_BLACK
				: ctx[i + hacl_pkg::PIXELS_PER_BYTE];
		end
		next_valid = !ends;
	end

endmodule

/* hdl/hacl_out_buf.sv */
// hacl_out_buf: result register for one batch of up to 14 pixels, shifted out
// one pixel per cycle under the output stall.
// Depends on hacl_pkg.
module hacl_out_buf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  hacl_pkg::color_t     colors [hacl_pkg::MAX_OUT],
	input  hacl_pkg::batch_ctl_t ctl,
	output logic                 can_load,
	output logic                 out_valid,
	input  logic                 out_stall,
	output hacl_pkg::color_t     pixel_color,
	output logic                 last_of_run,
	output logic                 end_of_line
);

	hacl_pkg::color_t buf_q [hacl_pkg::MAX_OUT];
	hacl_pkg::cnt_t   cnt_q;
	logic             eol_q;
	logic             adv;

	// handshake
	assign out_valid = cnt_q != '0;
	assign adv       = out_valid && !out_stall;
	assign can_load  = (cnt_q == '0) || (cnt_q == hacl_pkg::cnt_t'(1) && adv);

	// payload
	assign pixel_color = buf_q[0];
	assign last_of_run = cnt_q == hacl_pkg::cnt_t'(1);
	assign end_of_line = last_of_run && eol_q;

	// remaining count and line end flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			eol_q <= 1'b0;
		end else if (load) begin
			cnt_q <= ctl.count;
			eol_q <= ctl.eol;
		end else if (adv) begin
			cnt_q <= cnt_q - hacl_pkg::cnt_t'(1);
		end
	end

	// pixel shift register
	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= colors;
		end else if (adv) begin
			for (int i = 0; i < hacl_pkg::MAX_OUT - 1; i++) begin
				buf_q[i] <= buf_q[i + 1];
			end
		end
	end

	// a batch never overwrites pixels still waiting
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (cnt_q == '0 || (cnt_q == hacl_pkg::cnt_t'(1) && adv)))
		else $error("batch loaded over waiting pixels");

	// a loaded batch shows its full count next cycle
	a_load_count: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> cnt_q == $past(ctl.count))
		else $error("batch count not taken");

	// each delivered pixel removes exactly one from the count
	a_adv_count: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !load) |=> cnt_q == $past(cnt_q) - hacl_pkg::cnt_t'(1))
		else $error("pixel count out of step");

	// count stays within one batch
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= hacl_pkg::cnt_t'(hacl_pkg::MAX_OUT))
		else $error("pixel count beyond batch size");

endmodule

/* hdl/hires_artifact_color_line.sv */
// hires_artifact_color_line: top level; input register, pixel window state,
// mono register, pixel unit and output buffer.
// Depends on hacl_pkg, hacl_pixel_unit, hacl_out_buf.
//
//   channel  handshake              payload
//   in       in_valid / in_stall    video_byte, column
//   out      out_valid / out_stall  pixel_color, last_of_run, end_of_line
//   cfg      cfg_valid / cfg_ready  mono_mode
//
// One pixel leaves per cycle while out_stall is low; the output shift register sets
// the pace. A byte releases 7 pixels in steady state, 14 for the last byte of a line
// and none for the first.
// A byte is taken into the input register while the previous batch drains and
// is smoothed and loaded into the output buffer as the buffer frees up.
// Reset clears the window, its valid flag, mono mode and both valid stages.
// The configuration port is always ready.
module hires_artifact_color_line (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [hacl_pkg::BYTE_W-1:0] video_byte,
	input  logic [hacl_pkg::COL_W-1:0]  column,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [3:0]                  pixel_color,
	output logic                        last_of_run,
	output logic                        end_of_line,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic                        mono_mode
);

	logic                        valid_s1;
	logic [hacl_pkg::BYTE_W-1:0] byte_s1;
	logic [hacl_pkg::COL_W-1:0]  col_s1;
	logic                        mono_q;
	hacl_pkg::color_t            win_q [hacl_pkg::WIN_DEPTH];
	logic                        win_valid_q;
	hacl_pkg::color_t            colors [hacl_pkg::MAX_OUT];
	hacl_pkg::batch_ctl_t        ctl;
	hacl_pkg::color_t            next_win [hacl_pkg::WIN_DEPTH];
	logic                        next_valid;
	logic                        can_load;
	logic                        load;
	logic                        in_take;

	// request flow
	assign load     = valid_s1 && can_load;
	assign in_stall = valid_s1 && !can_load;
	assign in_take  = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// mono mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mono_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			mono_q <= mono_mode;
		end
	end

	// input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (load) begin
			valid_s1 <= 1'b0;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= video_byte;
			col_s1  <= column;
		end
	end

	// pixel window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_valid_q <= 1'b0;
			for (int i = 0; i < hacl_pkg::WIN_DEPTH; i++) begin
				win_q[i] <= hacl_pkg::COLOR_BLACK;
			end
		end else if (load) begin
			win_valid_q <= next_valid;
			win_q       <= next_win;
		end
	end

	hacl_pixel_unit u_pixel (
		.video_byte (byte_s1),
		.column     (col_s1),
		.mono       (mono_q),
		.win        (win_q),
		.win_valid  (win_valid_q),
		.colors     (colors),
		.ctl        (ctl),
		.next_win   (next_win),
		.next_valid (next_valid)
	);

	hacl_out_buf u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (load),
		.colors      (colors),
		.ctl         (ctl),
		.can_load    (can_load),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pixel_color (pixel_color),
		.last_of_run (last_of_run),
		.end_of_line (end_of_line)
	);

endmodule
